// File: src/acrs_pkg.sv
package acrs_pkg;

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_SKIP = 3'd1,
        EV_DATA = 3'd2,
        EV_PAL  = 3'd3,
        EV_EOD  = 3'd4
    } evt_code_t;

    // configuration register indexes
    localparam logic REG_DATA_END     = 1'b0;
    localparam logic REG_STREAM_COUNT = 1'b1;

    // tag characters
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_U    = 8'h55;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [6:0] NO_STREAM   = 7'd100;
    localparam logic [2:0] HITS_LIMIT  = 3'd5;
    localparam logic [2:0] HITS_MAX    = 3'd7;
    localparam logic [3:0] YOUNG_LIMIT = 4'd9;
    localparam logic [3:0] WIN_FULL    = 4'd7;
    localparam logic [3:0] IDX_MAX     = 4'd15;

    typedef struct packed {
        logic [15:0] prefix;
        logic [2:0]  hits;
    } pfx_entry_t;

    typedef struct packed {
        logic       en;
        pfx_entry_t data;
    } pfx_wr_t;

    typedef struct packed {
        evt_code_t   ev;
        logic [3:0]  stream_id;
        logic [31:0] chunk_size;
        logic [15:0] chunk_code;
    } result_t;

    // two ascii digits to a stream number, NO_STREAM otherwise
    function automatic logic [6:0] two_digit(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] ha;
        logic [6:0] hb;
        ha = {3'b000, a[3:0]};
        hb = {3'b000, b[3:0]};
        if (a >= CH_ZERO && a <= CH_NINE && b >= CH_ZERO && b <= CH_NINE)
        begin
            return (ha << 3) + (ha << 1) + hb;
        end
        return NO_STREAM;
    endfunction

endpackage

// File: src/avi_chunk_header_resync_core.sv
// result path: a result beat is registered in the output stage, or in the skid stage while the output stage is full
// throughput: one byte per cycle while the skid stage is empty, set by the window shift and the
//   early registered read of the stream prefix table
// reset: scan closed, window cleared, prefix table valid bits cleared at once,
//   so the block takes bytes as soon as reset is released
module avi_chunk_header_resync_core
    import acrs_pkg::*;
#(
    parameter int MAX_STREAMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    // byte beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic [47:0] byte_pos,
    input  logic        scan_start,
    // result beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [3:0]  stream_id,
    output logic [31:0] chunk_size,
    output logic [15:0] chunk_code
);

    // prefix table address width follows the stream count
    localparam int AW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

    logic [47:0] data_end_reg;
    logic [47:0] data_end_next;
    logic [4:0]  stream_count_reg;
    logic [4:0]  stream_count_next;
    logic        accept;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    pfx_entry_t  rd_data;
    pfx_wr_t     wr;
    result_t     res;
    result_t     out_data;

    // configuration registers; the user must write them only while idle, the block itself does not enforce it
    always_comb
    begin
        data_end_next     = data_end_reg;
        stream_count_next = stream_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DATA_END:     data_end_next     = cfg_data;
                REG_STREAM_COUNT: stream_count_next = cfg_data[4:0];
                default:          data_end_next     = data_end_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_end_reg     <= 48'd0;
            stream_count_reg <= 5'd0;
        end
        else
        begin
            data_end_reg     <= data_end_next;
            stream_count_reg <= stream_count_next;
        end
    end

    // a byte beat is taken whenever the skid stage has room
    assign accept = in_valid && in_ready;

    // window, scan counter and chunk classification; the table entry for
    // the stream the window will name is read into a register before it is needed
    acrs_scan #(
        .MAX_STREAMS (MAX_STREAMS),
        .AW          (AW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_value   (byte_value),
        .byte_pos     (byte_pos),
        .scan_start   (scan_start),
        .data_end     (data_end_reg),
        .stream_count (stream_count_reg),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr           (wr),
        .res          (res)
    );

    // per-stream learned prefix and hit count, forwarded on same-entry access
    acrs_pfx_mem #(
        .DEPTH (MAX_STREAMS),
        .AW    (AW)
    ) u_pfx_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr      (wr)
    );

    // output register with skid so a single waiting result does not stall
    // the input; input stalls only once both stages hold a result
    acrs_out_skid u_out_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (accept),
        .up_ready (in_ready),
        .up_data  (res),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_data  (out_data)
    );

    assign event_res  = out_data.ev;
    assign stream_id  = out_data.stream_id;
    assign chunk_size = out_data.chunk_size;
    assign chunk_code = out_data.chunk_code;

`ifndef SYNTHESIS
    // a byte at or past the data end always reports end of data
    a_eod_event: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_pos >= data_end_reg) |-> (res.ev == EV_EOD))
        else $error("end of data not reported");

    // the prefix table is only written for an accepted data chunk
    a_wr_data_only: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (accept && res.ev == EV_DATA))
        else $error("prefix table written without data chunk");

    // events without a chunk carry zero fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_NONE || event_res == EV_EOD))
            |-> (stream_id == 4'd0 && chunk_size == 32'd0 && chunk_code == 16'd0))
        else $error("fields set on an event without a chunk");
`endif

endmodule

// File: src/acrs_pfx_mem.sv
module acrs_pfx_mem
    import acrs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output pfx_entry_t    rd_data,
    input  logic [AW-1:0] wr_addr,
    input  pfx_wr_t       wr
);

    pfx_entry_t       pfx_mem [DEPTH];
    pfx_entry_t       rd_mem_reg;
    pfx_entry_t       fwd_data_reg;
    logic             fwd_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    // entries never written read as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pfx_mem[wr_addr] <= wr.data;
        end
        rd_mem_reg   <= pfx_mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
            fwd_reg      <= wr.en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : (rd_valid_reg ? rd_mem_reg : '0);

endmodule

// File: src/acrs_scan.sv
module acrs_scan
    import acrs_pkg::*;
#(
    parameter int MAX_STREAMS = 16,
    parameter int AW          = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    byte_value,
    input  logic [47:0]   byte_pos,
    input  logic          scan_start,
    input  logic [47:0]   data_end,
    input  logic [4:0]    stream_count,
    input  pfx_entry_t    rd_data,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr,
    output pfx_wr_t       wr,
    output result_t       res
);

    localparam logic [6:0] MAX_CNT = 7'(MAX_STREAMS);

    logic [7:0]  win_reg [8];
    logic [7:0]  win_next [8];
    logic [7:0]  base_win [8];
    logic [7:0]  d [8];
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic [3:0]  base_idx;
    logic        closed_reg;
    logic        closed_next;
    logic        clear;
    logic        eod;
    logic        fits;
    logic        young;
    logic        match;
    logic        is_ix;
    logic        is_junk;
    logic [48:0] end_sum;
    logic [31:0] size;
    logic [15:0] code;
    logic [6:0]  count;
    logic [6:0]  n_ix;
    logic [6:0]  n_dat;
    logic [6:0]  n_pre;

    assign count = ({2'b00, stream_count} > MAX_CNT) ? MAX_CNT : {2'b00, stream_count};

    // window after this byte, before event handling
    always_comb
    begin
        clear    = scan_start || closed_reg;
        base_idx = clear ? 4'd0 : idx_reg;
        for (int i = 0; i < 8; i++)
        begin
            base_win[i] = clear ? 8'd0 : win_reg[i];
        end
        for (int i = 0; i < 7; i++)
        begin
            d[i] = base_win[i+1];
        end
        d[7] = byte_value;
    end

    assign eod     = byte_pos >= data_end;
    assign size    = {d[7], d[6], d[5], d[4]};
    assign code    = {d[2], d[3]};
    assign end_sum = {1'b0, byte_pos} + 49'(size);
    assign fits    = end_sum <= {1'b0, data_end};
    assign young   = base_idx < YOUNG_LIMIT;
    assign n_ix    = two_digit(d[2], d[3]);
    assign n_dat   = two_digit(d[0], d[1]);
    assign is_ix   = (d[0] == CH_I) && (d[1] == CH_X) && (n_ix < count);
    assign is_junk = (d[0] == CH_J) && (d[1] == CH_U) && (d[2] == CH_N) && (d[3] == CH_K);
    assign match   = code == rd_data.prefix;

    // classification and table update
    always_comb
    begin
        res         = '0;
        wr          = '0;
        wr.data     = rd_data;
        closed_next = closed_reg;
        idx_next    = idx_reg;
        win_next    = win_reg;
        if (accept)
        begin
            closed_next = 1'b0;
            if (eod)
            begin
                win_next    = base_win;
                idx_next    = base_idx;
                res.ev      = EV_EOD;
                closed_next = 1'b1;
            end
            else
            begin
                win_next = d;
                idx_next = (base_idx < IDX_MAX) ? base_idx + 4'd1 : IDX_MAX;
                if (base_idx >= WIN_FULL && fits)
                begin
                    if (is_ix || is_junk)
                    begin
                        res.ev         = EV_SKIP;
                        res.stream_id  = (d[0] == CH_I) ? n_ix[3:0] : 4'd0;
                        res.chunk_size = size;
                        res.chunk_code = code;
                        closed_next    = 1'b1;
                    end
                    else if (n_dat < count)
                    begin
                        if (match || ((rd_data.hits < HITS_LIMIT || young)
                                      && !d[2][7] && !d[3][7]))
                        begin
                            wr.en = 1'b1;
                            if (match)
                            begin
                                if (rd_data.hits < HITS_MAX)
                                begin
                                    wr.data.hits = rd_data.hits + 3'd1;
                                end
                            end
                            else
                            begin
                                wr.data.prefix = code;
                                wr.data.hits   = 3'd0;
                            end
                            res.ev         = EV_DATA;
                            res.stream_id  = n_dat[3:0];
                            res.chunk_size = size;
                            res.chunk_code = code;
                            closed_next    = 1'b1;
                        end
                        else if (d[2] == CH_P && d[3] == CH_C)
                        begin
                            res.ev         = EV_PAL;
                            res.stream_id  = n_dat[3:0];
                            res.chunk_size = size;
                            res.chunk_code = code;
                            closed_next    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // stream number the next byte would name, read ahead through the table's read register
    assign n_pre   = two_digit(win_next[1], win_next[2]);
    assign rd_addr = (n_pre < MAX_CNT) ? n_pre[AW-1:0] : '0;
    assign wr_addr = (n_dat < MAX_CNT) ? n_dat[AW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            idx_reg    <= 4'd0;
            closed_reg <= 1'b1;
        end
        else
        begin
            win_reg    <= win_next;
            idx_reg    <= idx_next;
            closed_reg <= closed_next;
        end
    end

endmodule

// File: src/acrs_out_skid.sv
module acrs_out_skid
    import acrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_ready,
    input  result_t up_data,
    output logic    dn_valid,
    input  logic    dn_ready,
    output result_t dn_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    assign up_ready = !skid_valid_reg;
    assign dn_valid = out_valid_reg;
    assign dn_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && dn_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (up_valid && up_ready)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = up_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = up_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule
